// ===== rtl/core/ccorr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccorr_pkg
// Shared constants, types and helpers of the complex cross-correlator.
// ----------------------------------------------------------------------------
package ccorr_pkg;

  localparam int NumAntennas = 12;
  localparam int MaxChannels = 4096;
  localparam int TriSize     = NumAntennas * (NumAntennas + 1) / 2;
  localparam int AntW        = 4;
  localparam int ChW         = 12;
  localparam int SumW        = 25;
  localparam int TimeW       = 16;
  localparam int AddrW       = 19;
  localparam int TriW        = 7;
  localparam int LogW        = 5;
  localparam int NchW        = 13;

  localparam logic [LogW-1:0] LogReset = 5'd10;
  localparam logic [NchW-1:0] NchReset = 13'd3072;
  localparam logic [LogW-1:0] LogMax   = 5'd16;

  localparam logic [1:0] RegIntLog = 2'd0;
  localparam logic [1:0] RegNch    = 2'd1;

  typedef struct packed {
    logic [ChW-1:0]  ch;
    logic [AntW-1:0] ant;
    logic            emit;
  } job_t;

  function automatic logic signed [3:0] nib_hi(input logic [7:0] b);
    return $signed(b[7:4]);
  endfunction

  function automatic logic signed [3:0] nib_lo(input logic [7:0] b);
    return $signed(b[3:0]);
  endfunction

  function automatic logic [TriW-1:0] tri_base(input logic [AntW-1:0] a);
    logic [TriW+AntW-1:0] p;
    p = {{TriW{1'b0}}, a} * ({{TriW{1'b0}}, a} + 1'b1);
    return p[TriW:1];
  endfunction

endpackage

// ===== rtl/core/complex_cross_correlator_top.sv =====
// ----------------------------------------------------------------------------
// complex_cross_correlator_top
// 4+4-bit complex X engine with per-channel baseline accumulation.
// ----------------------------------------------------------------------------
// After reset the block clears its 319488-entry baseline memory, one entry a
// cycle, and takes no item until then. Antenna j of a channel reads and
// writes back baseline entries 0 to j in turn through the single
// read-modify-write port of the baseline memory; on the last time sample each
// baseline also passes through StOut1 (diagonal) or StOut1 and StOut2 (others),
// which hold while the output is stalled.
module complex_cross_correlator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                sample_byte_valid_i,
  output logic                sample_byte_stall_o,
  input  logic [7:0]          sample_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [11:0]         channel_o,
  output logic [3:0]          row_antenna_o,
  output logic [3:0]          col_antenna_o,
  output logic signed [24:0]  vis_real_o,
  output logic signed [24:0]  vis_imag_o,
  output logic                last_o
);
  import ccorr_pkg::*;

  logic [LogW-1:0]  lg_q;
  logic [NchW-1:0]  nch_q;
  logic [AntW-1:0]  ant_q;
  logic [ChW-1:0]   ch_q;
  logic [TimeW-1:0] time_q;
  logic [7:0]       buf_q [NumAntennas];
  logic [AntW-1:0]  rd_idx;
  logic             busy, clr_busy, acc;
  logic [LogW-1:0]  lg;
  logic [NchW-1:0]  nch;
  logic [TimeW-1:0] last_time;
  logic             emit;
  job_t             job;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2] ? RegNch : RegIntLog;

  always_comb begin
    unique case (paddr[2])
      1'b0: prdata = 32'(lg_q);
      default: prdata = 32'(nch_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= LogReset;
      nch_q <= NchReset;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == RegIntLog) lg_q <= pwdata[LogW-1:0];
      if (reg_idx == RegNch) nch_q <= pwdata[NchW-1:0];
    end
  end

  assign lg  = (lg_q > LogMax) ? LogMax : lg_q;
  assign nch = (nch_q == '0) ? NchW'(1)
             : (nch_q > NchW'(MaxChannels)) ? NchW'(MaxChannels) : nch_q;
  assign last_time = TimeW'((17'd1 << lg) - 17'd1);
  assign emit = time_q >= last_time;

  assign sample_byte_stall_o = busy;
  assign acc = sample_byte_valid_i && !busy;

  assign job.ch   = ch_q;
  assign job.ant  = ant_q;
  assign job.emit = emit;

  always_ff @(posedge clk_i) begin
    if (acc) buf_q[ant_q] <= sample_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ant_q  <= '0;
      ch_q   <= '0;
      time_q <= '0;
    end else if (acc) begin
      if (ant_q == AntW'(NumAntennas - 1)) begin
        ant_q <= '0;
        if (NchW'(ch_q) + 1'b1 >= nch) begin
          ch_q <= '0;
          time_q <= emit ? '0 : time_q + 1'b1;
        end else begin
          ch_q <= ch_q + 1'b1;
        end
      end else begin
        ant_q <= ant_q + 1'b1;
      end
    end
  end

  ccorr_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (acc),
    .job_i         (job),
    .smp_i         (sample_byte_i),
    .rd_idx_o      (rd_idx),
    .rd_byte_i     (buf_q[rd_idx]),
    .busy_o        (busy),
    .clr_busy_o    (clr_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_o     (channel_o),
    .row_antenna_o (row_antenna_o),
    .col_antenna_o (col_antenna_o),
    .vis_real_o    (vis_real_o),
    .vis_imag_o    (vis_imag_o),
    .last_o        (last_o)
  );

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !acc) else $error("item taken during clear");
  a_ant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ant_q < AntW'(NumAntennas)) else $error("antenna position out of range");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy) else $error("not busy after item");
endmodule

// ===== rtl/core/ccorr_mac.sv =====
// ----------------------------------------------------------------------------
// ccorr_mac
// Baseline store with read-modify-write multiply-accumulate and emission.
// ----------------------------------------------------------------------------
module ccorr_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  ccorr_pkg::job_t              job_i,
  input  logic [7:0]                   smp_i,
  output logic [ccorr_pkg::AntW-1:0]   rd_idx_o,
  input  logic [7:0]                   rd_byte_i,
  output logic                         busy_o,
  output logic                         clr_busy_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ccorr_pkg::ChW-1:0]    channel_o,
  output logic [ccorr_pkg::AntW-1:0]   row_antenna_o,
  output logic [ccorr_pkg::AntW-1:0]   col_antenna_o,
  output logic signed [ccorr_pkg::SumW-1:0] vis_real_o,
  output logic signed [ccorr_pkg::SumW-1:0] vis_imag_o,
  output logic                         last_o
);
  import ccorr_pkg::*;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StWr   = 3'd3;
  localparam logic [2:0] StOut1 = 3'd4;
  localparam logic [2:0] StOut2 = 3'd5;

  localparam int Depth = MaxChannels * TriSize;

  logic [2*SumW-1:0] mem_q [Depth];
  logic [2*SumW-1:0] rdata_q;

  logic [2:0]       st_q, st_d;
  job_t             job_q;
  logic [7:0]       smp_q;
  logic [AntW-1:0]  i_q, i_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] addr;
  logic             we;
  logic [2*SumW-1:0] wdata;
  logic signed [SumW-1:0] re_q, im_q, re_n, im_n;
  logic signed [9:0] pre, pim;
  logic signed [9:0] rh, rl, sh, sl;
  logic signed [4:0] cross_pos, cross_neg;
  logic             ov_q, ov_d;

  assign rd_idx_o = i_q;

  always_comb begin
    logic [AddrW-1:0] b;
    b = AddrW'(job_q.ch) * AddrW'(TriSize);
    addr = b + AddrW'(tri_base(job_q.ant)) + AddrW'(i_q);
    if (st_q == StClr) addr = clr_q;
  end

  always_comb begin
    rh = 10'(nib_hi(rd_byte_i));
    rl = 10'(nib_lo(rd_byte_i));
    sh = 10'(nib_hi(smp_q));
    sl = 10'(nib_lo(smp_q));
    pre = rh * sh + rl * sl;
    pim = rl * sh - rh * sl;
    re_n = $signed(rdata_q[2*SumW-1:SumW]) + SumW'(pre);
    im_n = $signed(rdata_q[SumW-1:0]) + SumW'(pim);
  end

  assign cross_pos = '0;
  assign cross_neg = '0;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= wdata;
    rdata_q <= mem_q[addr];
  end

  always_comb begin
    st_d = st_q;
    i_d = i_q;
    clr_d = clr_q;
    ov_d = ov_q;
    we = 1'b0;
    wdata = {re_n, im_n};
    unique case (st_q)
      StClr: begin
        we = 1'b1;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          i_d = '0;
          st_d = StRd;
        end
      end
      StRd: st_d = StWr;
      StWr: begin
        we = 1'b1;
        if (job_q.emit) begin
          wdata = '0;
          st_d = StOut1;
        end else if (i_q == job_q.ant) begin
          st_d = StIdle;
        end else begin
          i_d = i_q + 1'b1;
          st_d = StRd;
        end
      end
      StOut1: begin
        if (!out_stall_i) begin
          if (i_q == job_q.ant) st_d = StIdle;
          else st_d = StOut2;
        end
      end
      StOut2: begin
        if (!out_stall_i) begin
          i_d = i_q + 1'b1;
          st_d = StRd;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StClr;
      clr_q <= '0;
      i_q   <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      i_q   <= i_d;
      ov_q  <= ov_d | (cross_pos != cross_neg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start_i) begin
      job_q <= job_i;
      smp_q <= smp_i;
    end
    if (st_q == StWr) begin
      re_q <= re_n;
      im_q <= im_n;
    end
  end

  assign busy_o        = (st_q != StIdle) || ov_q;
  assign clr_busy_o    = (st_q == StClr);
  assign out_valid_o   = (st_q == StOut1) || (st_q == StOut2);
  assign channel_o     = job_q.ch;
  assign row_antenna_o = (st_q == StOut2) ? job_q.ant : i_q;
  assign col_antenna_o = (st_q == StOut2) ? i_q : job_q.ant;
  assign vis_real_o    = re_q;
  assign vis_imag_o    = (st_q == StOut2) ? -im_q : im_q;
  assign last_o        = (st_q == StOut1) && (i_q == job_q.ant);

  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> job_q.emit) else $error("result without emit");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRd) |=> (st_q == StWr)) else $error("read not followed by write");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StWr) |-> (i_q <= job_q.ant)) else $error("index past antenna");
endmodule
